>>> rtl/qkd_pkg.sv
// Package for the quadrature knob and press decoder.
// Item types, register and event codes, reset values and the step table.
// No dependencies.
`default_nettype none

package qkd_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int STAMP_W       = 32;

  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

  localparam logic [3:0]  DETENT_RST     = 4'd4;
  localparam logic        REVERSE_RST    = 1'b0;
  localparam logic [31:0] DEBOUNCE_RST   = 32'd20000;
  localparam logic [31:0] LONG_PRESS_RST = 32'd800000;

  typedef enum logic [1:0] {
    CFG_DETENT     = 2'd0,
    CFG_REVERSE    = 2'd1,
    CFG_DEBOUNCE   = 2'd2,
    CFG_LONG_PRESS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_INC     = 2'd0,
    ACT_DEC     = 2'd1,
    ACT_CONFIRM = 2'd2,
    ACT_BACK    = 2'd3
  } action_t;

  typedef struct packed {
    logic              chan_a;
    logic              chan_b;
    logic              button_level;
    logic [STAMP_W-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    action_t action;
    logic    last;
  } out_item_t;

  typedef struct packed {
    cfg_reg_t    index;
    logic [31:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [3:0]  detent_steps;
    logic        reverse_direction;
    logic [31:0] debounce_time;
    logic [31:0] long_press_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  ev0;
    out_item_t  ev1;
  } push_t;

  // Indexed by {prev_a, prev_b, a, b}.
  localparam logic signed [1:0] STEP_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

endpackage

`default_nettype wire

>>> rtl/qkd_stream_if.sv
// Valid/ready channel carrying one item of payload type T.
// Depends on nothing; payload types come from qkd_pkg at instantiation.
`default_nettype none

interface qkd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/quadrature_knob_with_press_decode.sv
// Quadrature knob and push-button decoder, top level.
// Depends on qkd_pkg, qkd_stream_if, qkd_cfg, qkd_core and qkd_evq.
//
// Each input item is one poll sample (A/B levels, active-low button, microsecond
// timestamp) and yields zero, one or two events (increase, decrease, confirm,
// back), the final one of a sample marked by last. A sample is taken into an
// input register, decoded combinationally and written into a four-entry event
// queue, from which its events are offered. Samples are taken one per cycle as
// long as the consumer drains events; the input stalls while the queue holds
// more than two events. The queue hands out one event per cycle while the
// consumer is ready, so samples with at most one event are taken one per cycle
// and samples with two events no faster than the queue hands them out.
// The first sample after reset only loads the decoder state.
`default_nettype none

module quadrature_knob_with_press_decode #(
  parameter int TIME_BITS = qkd_pkg::TIME_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  qkd_stream_if.sink   in_ch,
  qkd_stream_if.source out_ch,
  qkd_stream_if.sink   cfg
);

  qkd_pkg::cfg_t  regs;
  qkd_pkg::push_t push;
  logic           space_ok;

  qkd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  qkd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .regs     (regs),
    .space_ok (space_ok),
    .push     (push)
  );

  qkd_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/qkd_cfg.sv
// Configuration registers of the knob decoder.
// Depends on qkd_pkg and qkd_stream_if.
`default_nettype none

module qkd_cfg (
  input  wire logic       clk,
  input  wire logic       rst,
  qkd_stream_if.sink      cfg,
  output qkd_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.detent_steps      <= qkd_pkg::DETENT_RST;
      regs.reverse_direction <= qkd_pkg::REVERSE_RST;
      regs.debounce_time     <= qkd_pkg::DEBOUNCE_RST;
      regs.long_press_time   <= qkd_pkg::LONG_PRESS_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        qkd_pkg::CFG_DETENT:     regs.detent_steps      <= cfg.data.value[3:0];
        qkd_pkg::CFG_REVERSE:    regs.reverse_direction <= cfg.data.value[0];
        qkd_pkg::CFG_DEBOUNCE:   regs.debounce_time     <= cfg.data.value;
        qkd_pkg::CFG_LONG_PRESS: regs.long_press_time   <= cfg.data.value;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/qkd_core.sv
// Input register and single-pass decode of rotation and button events.
// Depends on qkd_pkg and qkd_stream_if.
`default_nettype none

module qkd_core #(
  parameter int TIME_BITS = qkd_pkg::TIME_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  qkd_stream_if.sink         in_ch,
  input  wire qkd_pkg::cfg_t regs,
  input  wire logic          space_ok,
  output qkd_pkg::push_t     push
);

  localparam int CMP_W = (TIME_BITS > qkd_pkg::STAMP_W) ? TIME_BITS : qkd_pkg::STAMP_W;

  logic              item_valid;
  qkd_pkg::in_item_t item;
  logic              adv;

  logic                 primed;
  logic [1:0]           prev_ab;
  logic signed [4:0]    step_accum;
  logic                 stable_level;
  logic                 candidate_level;
  logic [TIME_BITS-1:0] change_stamp;
  logic [TIME_BITS-1:0] press_stamp;
  logic                 long_reported;

  logic [1:0]           prev_ab_next;
  logic signed [4:0]    step_accum_next;
  logic                 stable_level_next;
  logic                 candidate_level_next;
  logic [TIME_BITS-1:0] change_stamp_next;
  logic [TIME_BITS-1:0] press_stamp_next;
  logic                 long_reported_next;

  logic                 rot_v;
  qkd_pkg::action_t     rot_act;
  logic                 btn_v;
  qkd_pkg::action_t     btn_act;

  assign adv         = item_valid && space_ok;
  assign in_ch.ready = !item_valid || space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item <= in_ch.data;
    end
  end

  always_comb begin
    logic [1:0]           ab;
    logic                 raw;
    logic [CMP_W-1:0]     now_w;
    logic [TIME_BITS-1:0] now;
    logic signed [4:0]    acc;
    logic signed [4:0]    det;
    logic                 up;
    logic [TIME_BITS-1:0] since_change;
    logic [TIME_BITS-1:0] since_press;

    ab    = {item.chan_a, item.chan_b};
    raw   = item.button_level;
    now_w = CMP_W'(item.time_us);
    now   = now_w[TIME_BITS-1:0];

    prev_ab_next         = ab;
    step_accum_next      = step_accum;
    stable_level_next    = stable_level;
    candidate_level_next = candidate_level;
    change_stamp_next    = change_stamp;
    press_stamp_next     = press_stamp;
    long_reported_next   = long_reported;
    rot_v   = 1'b0;
    rot_act = qkd_pkg::ACT_INC;
    btn_v   = 1'b0;
    btn_act = qkd_pkg::ACT_CONFIRM;
    acc          = '0;
    det          = '0;
    up           = 1'b0;
    since_change = '0;
    since_press  = '0;

    if (!primed) begin
      step_accum_next      = '0;
      stable_level_next    = raw;
      candidate_level_next = raw;
      change_stamp_next    = now;
      press_stamp_next     = now;
      long_reported_next   = 1'b0;
    end else begin
      // rotation
      if ((prev_ab ^ ab) == 2'b11) begin
        acc = '0;
      end else begin
        acc = step_accum + {{3{qkd_pkg::STEP_TABLE[{prev_ab, ab}][1]}},
                            qkd_pkg::STEP_TABLE[{prev_ab, ab}]};
      end
      det = (regs.detent_steps == 4'd0) ? 5'sd1 : $signed({1'b0, regs.detent_steps});
      if (acc >= det || acc <= -det) begin
        up      = (acc > 5'sd0) ^ regs.reverse_direction;
        rot_v   = 1'b1;
        rot_act = up ? qkd_pkg::ACT_INC : qkd_pkg::ACT_DEC;
        acc     = '0;
      end
      step_accum_next = acc;

      // button debounce
      if (raw != candidate_level) begin
        candidate_level_next = raw;
        change_stamp_next    = now;
      end
      since_change = now - change_stamp_next;
      if (candidate_level_next != stable_level &&
          CMP_W'(since_change) >= CMP_W'(regs.debounce_time)) begin
        stable_level_next = candidate_level_next;
        if (!candidate_level_next) begin
          press_stamp_next   = now;
          long_reported_next = 1'b0;
        end else if (!long_reported) begin
          btn_v   = 1'b1;
          btn_act = qkd_pkg::ACT_CONFIRM;
        end
      end
      since_press = now - press_stamp_next;
      if (!stable_level_next && !long_reported_next &&
          CMP_W'(since_press) >= CMP_W'(regs.long_press_time)) begin
        btn_v              = 1'b1;
        btn_act            = qkd_pkg::ACT_BACK;
        long_reported_next = 1'b1;
      end
    end
  end

  always_comb begin
    push.n          = adv ? ({1'b0, rot_v} + {1'b0, btn_v}) : 2'd0;
    push.ev0.action = rot_v ? rot_act : btn_act;
    push.ev0.last   = !(rot_v && btn_v);
    push.ev1.action = btn_act;
    push.ev1.last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed          <= 1'b0;
      prev_ab         <= '0;
      step_accum      <= '0;
      stable_level    <= 1'b1;
      candidate_level <= 1'b1;
      change_stamp    <= '0;
      press_stamp     <= '0;
      long_reported   <= 1'b0;
    end else if (adv) begin
      primed          <= 1'b1;
      prev_ab         <= prev_ab_next;
      step_accum      <= step_accum_next;
      stable_level    <= stable_level_next;
      candidate_level <= candidate_level_next;
      change_stamp    <= change_stamp_next;
      press_stamp     <= press_stamp_next;
      long_reported   <= long_reported_next;
    end
  end

  a_unprimed_idle: assert property (@(posedge clk) disable iff (rst)
    !primed |-> step_accum == 5'sd0 && push.n == 2'd0)
    else $error("events or steps before priming sample");

  a_back_latched: assert property (@(posedge clk) disable iff (rst)
    adv && btn_v && btn_act == qkd_pkg::ACT_BACK |=> long_reported)
    else $error("back reported without latching long press");

  a_accum_range: assert property (@(posedge clk) disable iff (rst)
    step_accum != -5'sd16)
    else $error("step accumulator out of range");

endmodule

`default_nettype wire

>>> rtl/qkd_evq.sv
// Event queue: takes up to two events per cycle, hands out one per cycle while the consumer is ready.
// Depends on qkd_pkg and qkd_stream_if.
`default_nettype none

module qkd_evq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire qkd_pkg::push_t push,
  output logic                space_ok,
  qkd_stream_if.source        out_ch
);

  localparam int DEPTH = qkd_pkg::EVQ_DEPTH;
  localparam int AW    = qkd_pkg::EVQ_AW;

  qkd_pkg::out_item_t mem [DEPTH];
  logic [AW-1:0]      rptr;
  logic [AW-1:0]      wptr;
  logic [AW:0]        count;
  logic [AW:0]        count_next;
  logic               pop;

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = count != '0;
  assign out_ch.data  = mem[rptr];
  assign space_ok     = count <= (AW+1)'(DEPTH - 2);
  assign count_next   = count + (AW+1)'(push.n) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      rptr  <= rptr + AW'(pop);
      wptr  <= wptr + AW'(push.n);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wptr] <= push.ev0;
    end
    if (push.n == 2'd2) begin
      mem[wptr + AW'(1)] <= push.ev1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> count + (AW+1)'(push.n) <= (AW+1)'(DEPTH))
    else $error("event queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("event queue count out of range");

endmodule

`default_nettype wire

>>> verif/knob_event_check.sv
// Event checker for the quadrature knob and press decoder: watches the sample,
// event and register channels, predicts the events of every sample and compares.
// Depends on qkd_pkg.
`timescale 1ns / 100ps

module knob_event_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  qkd_pkg::in_item_t  in_item,
  input  logic               ev_valid,
  input  logic               ev_ready,
  input  qkd_pkg::out_item_t ev_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  qkd_pkg::cfg_item_t cfg_item,
  output int                 mismatches,
  output int                 events_due
);

  localparam int STEP_DELTA [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  qkd_pkg::cfg_t      knob_cfg;
  logic               primed;
  logic [1:0]         prev_ab;
  int                 step_sum;
  logic               stable_lvl;
  logic               cand_lvl;
  logic [31:0]        change_us;
  logic [31:0]        press_us;
  logic               back_sent;
  qkd_pkg::out_item_t pending_events [$];

  task automatic decode_sample(input qkd_pkg::in_item_t s);
    logic [1:0]         ab;
    logic [31:0]        held;
    int                 detent;
    int                 n;
    int                 i;
    bit                 up;
    qkd_pkg::out_item_t ev [2];
    ab = {s.chan_a, s.chan_b};
    n = 0;
    if (!primed) begin
      primed = 1'b1;
      prev_ab = ab;
      step_sum = 0;
      stable_lvl = s.button_level;
      cand_lvl = s.button_level;
      change_us = s.time_us;
      press_us = s.time_us;
      back_sent = 1'b0;
    end else begin
      if ((prev_ab ^ ab) == 2'b11) begin
        step_sum = 0;
      end else begin
        step_sum += STEP_DELTA[{prev_ab, ab}];
      end
      prev_ab = ab;
      detent = (knob_cfg.detent_steps == 4'd0) ? 1 : int'(knob_cfg.detent_steps);
      if (step_sum >= detent || step_sum <= -detent) begin
        up = step_sum > 0;
        if (knob_cfg.reverse_direction) begin
          up = !up;
        end
        if (up) begin
          ev[n].action = qkd_pkg::ACT_INC;
        end else begin
          ev[n].action = qkd_pkg::ACT_DEC;
        end
        n++;
        step_sum = 0;
      end
      if (s.button_level != cand_lvl) begin
        cand_lvl = s.button_level;
        change_us = s.time_us;
      end
      held = s.time_us - change_us;
      if (cand_lvl != stable_lvl && held >= knob_cfg.debounce_time) begin
        stable_lvl = cand_lvl;
        if (stable_lvl == 1'b0) begin
          press_us = s.time_us;
          back_sent = 1'b0;
        end else if (!back_sent) begin
          ev[n].action = qkd_pkg::ACT_CONFIRM;
          n++;
        end
      end
      held = s.time_us - press_us;
      if (stable_lvl == 1'b0 && !back_sent && held >= knob_cfg.long_press_time) begin
        ev[n].action = qkd_pkg::ACT_BACK;
        n++;
        back_sent = 1'b1;
      end
      for (i = 0; i < n; i++) begin
        ev[i].last = (i == n - 1);
        pending_events.push_back(ev[i]);
      end
    end
  endtask

  always @(posedge clk) begin
    qkd_pkg::out_item_t exp_ev;
    if (rst) begin
      knob_cfg = '{qkd_pkg::DETENT_RST, qkd_pkg::REVERSE_RST, qkd_pkg::DEBOUNCE_RST,
                   qkd_pkg::LONG_PRESS_RST};
      primed = 1'b0;
      prev_ab = 2'b00;
      step_sum = 0;
      stable_lvl = 1'b1;
      cand_lvl = 1'b1;
      change_us = '0;
      press_us = '0;
      back_sent = 1'b0;
      pending_events.delete();
      mismatches = 0;
      events_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_item.index)
          qkd_pkg::CFG_DETENT:     knob_cfg.detent_steps = cfg_item.value[3:0];
          qkd_pkg::CFG_REVERSE:    knob_cfg.reverse_direction = cfg_item.value[0];
          qkd_pkg::CFG_DEBOUNCE:   knob_cfg.debounce_time = cfg_item.value;
          qkd_pkg::CFG_LONG_PRESS: knob_cfg.long_press_time = cfg_item.value;
          default: ;
        endcase
      end
      if (ev_valid && ev_ready) begin
        if (pending_events.size() == 0) begin
          $error("event with none expected: action %0d last %0d", ev_item.action, ev_item.last);
          mismatches++;
        end else begin
          exp_ev = pending_events.pop_front();
          if (ev_item.action !== exp_ev.action) begin
            $error("action: expected %0d, got %0d", exp_ev.action, ev_item.action);
            mismatches++;
          end
          if (ev_item.last !== exp_ev.last) begin
            $error("last: expected %0d, got %0d", exp_ev.last, ev_item.last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_sample(in_item);
      end
      events_due <= pending_events.size();
    end
  end

endmodule

>>> verif/tb.sv
// Testbench top for the quadrature knob and press decoder: clock, reset, sample
// and register stimulus, event sink stalls and the verdict.
// Depends on qkd_pkg, qkd_stream_if, the decoder and knob_event_check.
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_ITEMS = 588;
  localparam int PHASES       = 7;

  logic clk;
  logic rst;
  int   mismatches;
  int   events_due;

  logic [1:0]    enc_pos;
  bit            spin_up;
  logic          btn_lvl;
  int            btn_hold;
  logic [31:0]   now_us;
  qkd_pkg::cfg_t cur_cfg;
  int            burst_left;
  bit            choke_req;

  qkd_stream_if #(.T(qkd_pkg::in_item_t))  sample_ch ();
  qkd_stream_if #(.T(qkd_pkg::out_item_t)) event_ch ();
  qkd_stream_if #(.T(qkd_pkg::cfg_item_t)) reg_ch ();

  quadrature_knob_with_press_decode i_dut (
    .clk,
    .rst,
    .in_ch(sample_ch),
    .out_ch(event_ch),
    .cfg(reg_ch)
  );

  knob_event_check i_check (
    .clk,
    .rst,
    .in_valid(sample_ch.valid),
    .in_ready(sample_ch.ready),
    .in_item(sample_ch.data),
    .ev_valid(event_ch.valid),
    .ev_ready(event_ch.ready),
    .ev_item(event_ch.data),
    .cfg_valid(reg_ch.valid),
    .cfg_ready(reg_ch.ready),
    .cfg_item(reg_ch.data),
    .mismatches,
    .events_due
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** quadrature_knob_with_press_decode: FAILED **");
    $finish;
  end

  initial begin : event_sink
    int mode;
    int span;
    int k;
    event_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        event_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(1, 40);
        for (k = 0; k < span; k++) begin
          case (mode)
            0:       event_ch.ready <= 1'b1;
            1:       event_ch.ready <= 1'($urandom_range(0, 1));
            2:       event_ch.ready <= (k >= 6);
            default: event_ch.ready <= ($urandom_range(0, 4) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_sample(input logic a, input logic b, input logic btn,
                             input logic [31:0] t, input bit paced);
    sample_ch.valid <= 1'b1;
    sample_ch.data <= '{chan_a: a, chan_b: b, button_level: btn, time_us: t};
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (paced) begin
      pace();
    end
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(input qkd_pkg::cfg_t c);
    int                r;
    int                rot;
    qkd_pkg::cfg_reg_t idx;
    logic [31:0]       v;
    rot = $urandom_range(0, 3);
    reg_ch.valid <= 1'b1;
    for (r = 0; r < 4; r++) begin
      idx = qkd_pkg::cfg_reg_t'((r + rot) % 4);
      case (idx)
        qkd_pkg::CFG_DETENT:     v = (($urandom() >> 4) << 4) | 32'(c.detent_steps);
        qkd_pkg::CFG_REVERSE:    v = (($urandom() >> 1) << 1) | 32'(c.reverse_direction);
        qkd_pkg::CFG_DEBOUNCE:   v = c.debounce_time;
        qkd_pkg::CFG_LONG_PRESS: v = c.long_press_time;
        default:                 v = '0;
      endcase
      reg_ch.data <= '{index: idx, value: v};
      @(posedge clk);
      while (!reg_ch.ready) @(posedge clk);
    end
    reg_ch.valid <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic random_sample(input bit paced);
    int          pick;
    logic [1:0]  ab;
    logic        lvl;
    logic [31:0] delta;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      enc_pos = spin_up ? enc_pos + 2'd1 : enc_pos - 2'd1;
    end else if (pick < 80) begin
      enc_pos = enc_pos;
    end else if (pick < 90) begin
      spin_up = !spin_up;
      enc_pos = spin_up ? enc_pos + 2'd1 : enc_pos - 2'd1;
    end else begin
      enc_pos = 2'($urandom_range(0, 3));
    end
    ab = {enc_pos[1], enc_pos[1] ^ enc_pos[0]};
    if (btn_hold > 0) begin
      btn_hold--;
    end else begin
      btn_lvl = !btn_lvl;
      btn_hold = $urandom_range(0, 30);
    end
    lvl = ($urandom_range(0, 99) < 8) ? !btn_lvl : btn_lvl;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      delta = '0;
    end else if (pick < 55) begin
      delta = $urandom_range(0, cur_cfg.debounce_time / 4 + 1);
    end else if (pick < 90) begin
      delta = $urandom_range(0, cur_cfg.long_press_time / 4 + 1);
    end else begin
      delta = $urandom();
    end
    now_us = now_us + delta;
    send_sample(ab[1], ab[0], lvl, now_us, paced);
  endtask

  initial begin : stimulus
    qkd_pkg::cfg_t phases [PHASES];
    int            p;
    int            n;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    reg_ch.valid = 1'b0;
    reg_ch.data = '0;
    choke_req = 1'b0;
    burst_left = 0;
    enc_pos = 2'd0;
    spin_up = 1'b1;
    btn_lvl = 1'b1;
    btn_hold = 0;
    cur_cfg = '{qkd_pkg::DETENT_RST, qkd_pkg::REVERSE_RST, qkd_pkg::DEBOUNCE_RST,
                qkd_pkg::LONG_PRESS_RST};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0, 1'b1);
    send_sample(1'b0, 1'b1, 1'b0, 32'h0000_0010, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0, 32'h0000_0020, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0, 32'h0000_0030, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 32'h0000_0040, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0, 32'h0000_0050, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0, 32'h000C_34F0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1, 32'h000C_3500, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0, 32'h000C_3600, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1, 32'h000C_3700, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1, 32'h000C_8520, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0, 32'h000D_0000, 1'b1);
    send_sample(1'b0, 1'b1, 1'b0, 32'h000D_4E20, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1, 32'h000D_5000, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1, 32'h000D_9E20, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 32'h0000_4E1F, 1'b1);
    send_sample(1'b0, 1'b1, 1'b0, 32'h0008_0000, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0, 32'h000C_831F, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1, 32'h000D_0000, 1'b1);
    send_sample(1'b1, 1'b1, 1'b1, 32'h000E_0000, 1'b1);
    now_us = 32'h000E_0000;
    enc_pos = 2'd2;

    phases[0] = '{4'd1, 1'b1, 32'd0, 32'd1};
    phases[1] = '{4'd15, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    phases[2] = '{4'd4, 1'b0, 32'd100, 32'd1000};
    phases[3] = '{4'd0, 1'b1, 32'd50, 32'd0};
    phases[4] = '{4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)),
                  32'($urandom_range(0, 500)), 32'($urandom_range(1, 5000))};
    phases[5] = '{4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)),
                  32'($urandom_range(0, 500)), 32'($urandom_range(1, 5000))};
    phases[6] = '{4'd2, 1'b1, 32'd20000, 32'd800000};

    for (p = 0; p < PHASES; p++) begin
      drain();
      program_regs(phases[p]);
      if (p == 2) begin
        choke_req = 1'b1;
        for (n = 0; n < 40; n++) begin
          random_sample(1'b0);
        end
      end
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        random_sample(1'b1);
        if ($urandom_range(0, 49) == 0) begin
          drain();
        end
      end
    end

    drain();
    if (mismatches == 0 && events_due == 0) begin
      $display("** quadrature_knob_with_press_decode: PASSED **");
    end else begin
      $display("** quadrature_knob_with_press_decode: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/qkd_pkg.sv
rtl/qkd_stream_if.sv
rtl/qkd_cfg.sv
rtl/qkd_core.sv
rtl/qkd_evq.sv
rtl/quadrature_knob_with_press_decode.sv
verif/knob_event_check.sv
verif/tb.sv
